FILE: sv/tsp_pkg.sv
// ----------------------------------------------------------------------------
// tsp_pkg
// Types and constants for the transport stream packet header parser.
// ----------------------------------------------------------------------------
package tsp_pkg;

    localparam logic [7:0] SYNC_BYTE    = 8'h47;
    localparam logic [7:0] PACKET_BYTES = 8'd188;
    localparam logic [7:0] LAST_POS     = PACKET_BYTES - 8'd1;
    localparam logic [7:0] PAYLOAD_MAX  = PACKET_BYTES - 8'd4;
    localparam logic [7:0] PAYLOAD_ADPT = PACKET_BYTES - 8'd5;
    localparam logic [7:0] M2TS_SKIP    = 8'd4;

    // byte positions inside a packet
    localparam logic [7:0] POS_HDR1  = 8'd1;
    localparam logic [7:0] POS_HDR2  = 8'd2;
    localparam logic [7:0] POS_HDR3  = 8'd3;
    localparam logic [7:0] POS_ALEN  = 8'd4;
    localparam logic [7:0] POS_AFLG  = 8'd5;
    localparam logic [7:0] POS_PCR0  = 8'd6;
    localparam logic [7:0] POS_PCR1  = 8'd7;
    localparam logic [7:0] POS_PCR2  = 8'd8;
    localparam logic [7:0] POS_PCR3  = 8'd9;
    localparam logic [7:0] POS_PCR4  = 8'd10;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef enum logic {
        PH_HUNT    = 1'b0,
        PH_COLLECT = 1'b1
    } t_phase;

    typedef struct packed {
        logic        kind;
        logic [7:0]  data_byte;
        logic [7:0]  byte_offset;
        logic [12:0] packet_id;
        logic        error_flag;
        logic        unit_start;
        logic [3:0]  cont_counter;
        logic [32:0] pcr_value;
        logic        pcr_fresh;
        logic [7:0]  payload_len;
        logic        last;
    } t_result;

endpackage

FILE: sv/ts_packet_header_parser.sv
// ----------------------------------------------------------------------------
// ts_packet_header_parser
// Hunts for TS sync, parses the 4-byte header, adaptation length and PCR,
// emits payload bytes and one summary word per 188-byte packet.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one stream byte per word on i_in_byte, qualified by
//   i_valid; the block drives o_stall. Output channel: result words on the
//   o_* field ports, qualified by o_valid; the sink drives i_stall.
//   i_cfg_we/i_cfg_data write m2ts_mode (skip four bytes before each hunt);
//   write it only while the block is idle.
//   Throughput: one byte per cycle while o_stall is low. The last byte of
//   a packet can give two words (final payload byte and summary); a 4-entry
//   result queue absorbs this, and o_stall rises only when it holds three or
//   more words, which happens only while the sink stalls.
//   When the sink stalls, words wait in the queue and stay stable on the
//   outputs; input is held off once the queue is nearly full.
//   Reset (synchronous, active low) empties the queue, returns to sync hunt,
//   clears the held PCR and sets m2ts_mode to 0.
// ----------------------------------------------------------------------------
module ts_packet_header_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_in_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_kind,
    output logic [7:0]  o_data_byte,
    output logic [7:0]  o_byte_offset,
    output logic [12:0] o_packet_id,
    output logic        o_error_flag,
    output logic        o_unit_start,
    output logic [3:0]  o_cont_counter,
    output logic [32:0] o_pcr_value,
    output logic        o_pcr_fresh,
    output logic [7:0]  o_payload_len,
    output logic        o_last
);
    import tsp_pkg::*;

    // parser state
    t_phase      r_phase, n_phase;
    logic        r_m2ts;
    logic [7:0]  r_byte_pos, n_byte_pos;
    logic [23:0] r_header_word, n_header_word;
    logic [7:0]  r_adapt_len, n_adapt_len;
    logic [1:0]  r_adapt_ctrl, n_adapt_ctrl;
    logic        r_pcr_flag, n_pcr_flag;
    logic [32:0] r_pcr_accum, n_pcr_accum;
    logic [32:0] r_pcr_hold, n_pcr_hold;

    // result queue
    t_result     r_queue [4];
    logic [1:0]  r_wr_ptr, r_rd_ptr;
    logic [2:0]  r_count;

    logic        accept, pop;
    logic        has_adapt;
    logic [8:0]  pay_start;
    logic [7:0]  pay_len;
    logic        emit_pay, emit_sum;
    logic        push_a, push_b;
    t_result     res_pay, res_sum, res_a, res_b;

    assign accept  = i_valid && !o_stall;
    assign pop     = o_valid && !i_stall;
    assign o_stall = (r_count > 3'd2);
    assign o_valid = (r_count != 3'd0);

    assign has_adapt = r_adapt_ctrl[1];
    assign pay_start = has_adapt ? ({1'b0, r_adapt_len} + 9'd5) : 9'({1'b0, POS_ALEN});

    always_comb begin
        if (!has_adapt) begin
            pay_len = PAYLOAD_MAX;
        end else if (r_adapt_len >= PAYLOAD_MAX) begin
            pay_len = 8'd0;
        end else begin
            pay_len = PAYLOAD_ADPT - r_adapt_len;
        end
    end

    always_comb begin
        n_phase       = r_phase;
        n_byte_pos    = r_byte_pos;
        n_header_word = r_header_word;
        n_adapt_len   = r_adapt_len;
        n_adapt_ctrl  = r_adapt_ctrl;
        n_pcr_flag    = r_pcr_flag;
        n_pcr_accum   = r_pcr_accum;
        n_pcr_hold    = r_pcr_hold;
        emit_pay      = 1'b0;
        emit_sum      = 1'b0;
        case (r_phase)
            PH_HUNT: begin
                if (r_m2ts && r_byte_pos < M2TS_SKIP) begin
                    n_byte_pos = r_byte_pos + 8'd1;
                end else if (i_in_byte == SYNC_BYTE) begin
                    n_phase    = PH_COLLECT;
                    n_byte_pos = POS_HDR1;
                end
            end
            PH_COLLECT: begin
                if (r_byte_pos == POS_HDR1) begin
                    n_header_word = {i_in_byte, 16'h0000};
                end else if (r_byte_pos == POS_HDR2) begin
                    n_header_word = {r_header_word[23:16], i_in_byte, 8'h00};
                end else if (r_byte_pos == POS_HDR3) begin
                    n_header_word = {r_header_word[23:8], i_in_byte};
                    n_adapt_ctrl  = i_in_byte[5:4];
                    n_adapt_len   = 8'd0;
                    n_pcr_flag    = 1'b0;
                    n_pcr_accum   = 33'd0;
                end else begin
                    if (r_byte_pos == POS_ALEN && has_adapt) begin
                        n_adapt_len = i_in_byte;
                    end
                    if (r_byte_pos == POS_AFLG && has_adapt) begin
                        n_pcr_flag = i_in_byte[4];
                    end
                    if (r_pcr_flag) begin
                        case (r_byte_pos)
                            POS_PCR0: n_pcr_accum = {i_in_byte, 25'd0};
                            POS_PCR1: n_pcr_accum = r_pcr_accum | {8'd0, i_in_byte, 17'd0};
                            POS_PCR2: n_pcr_accum = r_pcr_accum | {16'd0, i_in_byte, 9'd0};
                            POS_PCR3: n_pcr_accum = r_pcr_accum | {24'd0, i_in_byte, 1'b0};
                            POS_PCR4: begin
                                n_pcr_accum = r_pcr_accum | {32'd0, i_in_byte[7]};
                                n_pcr_hold  = n_pcr_accum;
                            end
                            default: ;
                        endcase
                    end
                    emit_pay = !(r_byte_pos == POS_ALEN && has_adapt) && (pay_len != 8'd0)
                               && ({1'b0, r_byte_pos} >= pay_start)
                               && (r_byte_pos < PACKET_BYTES);
                end
                if (r_byte_pos >= LAST_POS) begin
                    emit_sum   = 1'b1;
                    n_phase    = PH_HUNT;
                    n_byte_pos = 8'd0;
                end else begin
                    n_byte_pos = r_byte_pos + 8'd1;
                end
            end
            default: begin
                n_phase = PH_HUNT;
            end
        endcase
    end

    always_comb begin
        res_pay.kind         = KIND_PAYLOAD;
        res_pay.data_byte    = i_in_byte;
        res_pay.byte_offset  = 8'({1'b0, r_byte_pos} - pay_start);
        res_pay.packet_id    = r_header_word[20:8];
        res_pay.error_flag   = r_header_word[23];
        res_pay.unit_start   = r_header_word[22];
        res_pay.cont_counter = r_header_word[3:0];
        res_pay.pcr_value    = 33'd0;
        res_pay.pcr_fresh    = 1'b0;
        res_pay.payload_len  = pay_len;
        res_pay.last         = !emit_sum;

        res_sum              = res_pay;
        res_sum.kind         = KIND_SUMMARY;
        res_sum.data_byte    = 8'd0;
        res_sum.byte_offset  = 8'd0;
        res_sum.pcr_value    = r_pcr_hold;
        res_sum.pcr_fresh    = has_adapt && r_pcr_flag;
        res_sum.last         = 1'b1;

        res_a  = emit_pay ? res_pay : res_sum;
        res_b  = res_sum;
        push_a = accept && (emit_pay || emit_sum);
        push_b = accept && emit_pay && emit_sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_HUNT;
            r_m2ts        <= 1'b0;
            r_byte_pos    <= 8'd0;
            r_header_word <= 24'd0;
            r_adapt_len   <= 8'd0;
            r_adapt_ctrl  <= 2'd0;
            r_pcr_flag    <= 1'b0;
            r_pcr_accum   <= 33'd0;
            r_pcr_hold    <= 33'd0;
        end else begin
            if (i_cfg_we) begin
                r_m2ts <= i_cfg_data;
            end
            if (accept) begin
                r_phase       <= n_phase;
                r_byte_pos    <= n_byte_pos;
                r_header_word <= n_header_word;
                r_adapt_len   <= n_adapt_len;
                r_adapt_ctrl  <= n_adapt_ctrl;
                r_pcr_flag    <= n_pcr_flag;
                r_pcr_accum   <= n_pcr_accum;
                r_pcr_hold    <= n_pcr_hold;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 2'd0;
            r_rd_ptr <= 2'd0;
            r_count  <= 3'd0;
        end else begin
            r_wr_ptr <= r_wr_ptr + {1'b0, push_a} + {1'b0, push_b};
            r_rd_ptr <= r_rd_ptr + {1'b0, pop};
            r_count  <= r_count + {2'b00, push_a} + {2'b00, push_b} - {2'b00, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_a) begin
            r_queue[r_wr_ptr] <= res_a;
        end
        if (push_b) begin
            r_queue[r_wr_ptr + 2'd1] <= res_b;
        end
    end

    assign o_kind         = r_queue[r_rd_ptr].kind;
    assign o_data_byte    = r_queue[r_rd_ptr].data_byte;
    assign o_byte_offset  = r_queue[r_rd_ptr].byte_offset;
    assign o_packet_id    = r_queue[r_rd_ptr].packet_id;
    assign o_error_flag   = r_queue[r_rd_ptr].error_flag;
    assign o_unit_start   = r_queue[r_rd_ptr].unit_start;
    assign o_cont_counter = r_queue[r_rd_ptr].cont_counter;
    assign o_pcr_value    = r_queue[r_rd_ptr].pcr_value;
    assign o_pcr_fresh    = r_queue[r_rd_ptr].pcr_fresh;
    assign o_payload_len  = r_queue[r_rd_ptr].payload_len;
    assign o_last         = r_queue[r_rd_ptr].last;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 3'd4)
        else $error("result queue overflow");

    a_collect_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_COLLECT) |-> (r_byte_pos >= POS_HDR1 && r_byte_pos <= LAST_POS))
        else $error("byte position out of packet range while collecting");

    a_summary_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind == KIND_SUMMARY) |-> (o_last && o_data_byte == 8'd0))
        else $error("summary word not marked last");

    a_payload_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind == KIND_PAYLOAD)
            |-> (o_byte_offset < o_payload_len && o_pcr_value == 33'd0))
        else $error("payload word offset beyond payload length");

    a_two_words_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push_b |-> (r_byte_pos == LAST_POS))
        else $error("double push away from packet end");
`endif

endmodule
